### src/mhis_pkg.sv
// Shared types and constants for the multi-heater interlock scheduler.
`timescale 1ns / 1ps

package mhis_pkg;

    // Heater lanes: front, back, down
    localparam int NUM_HEATERS = 3;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SEC_W      = 16;
    localparam int THR_MIN_W  = 12;

    // Register reset values
    localparam int MAX_TEMP_RST          = 640;
    localparam int MIN_TEMP_RST          = 480;
    localparam int MAX_HEAT_SECONDS_RST  = 600;
    localparam int MIN_PAUSE_SECONDS_RST = 60;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_TEMP          = 2'd0,
        REG_MIN_TEMP          = 2'd1,
        REG_MAX_HEAT_SECONDS  = 2'd2,
        REG_MIN_PAUSE_SECONDS = 2'd3
    } mhis_reg_idx_t;

    // Turn-on selection codes
    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_FRONT = 2'd1,
        SEL_BACK  = 2'd2,
        SEL_DOWN  = 2'd3
    } mhis_sel_t;

    // Per-lane findings handed to the merge stage
    typedef struct packed {
        logic force_off;
        logic candidate;
        logic blocked;
    } mhis_lane_t;

endpackage

### src/mhis_lane.sv
// One heater lane: on/off timers, edge detection, force-off and turn-on checks.
`timescale 1ns / 1ps

module mhis_lane #(
    parameter int TIMER_WIDTH = 16,
    parameter int TEMP_WIDTH  = 12,
    localparam int THR_W      = (TEMP_WIDTH > mhis_pkg::THR_MIN_W) ? TEMP_WIDTH
                                                                   : mhis_pkg::THR_MIN_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [TEMP_WIDTH-1:0]   temp,
    input  logic                           temp_valid,
    input  logic                           heater_on,
    input  logic                           heater_valid,
    input  logic signed [THR_W-1:0]        max_temp,
    input  logic signed [THR_W-1:0]        min_temp,
    input  logic [mhis_pkg::SEC_W-1:0]     max_heat_seconds,
    input  logic [mhis_pkg::SEC_W-1:0]     min_pause_seconds,
    output mhis_pkg::mhis_lane_t           lane
);
    import mhis_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > SEC_W) ? TIMER_WIDTH : SEC_W;

    logic                    last_on_reg;
    logic                    last_valid_reg;
    logic [TIMER_WIDTH-1:0]  since_on_reg;
    logic [TIMER_WIDTH-1:0]  since_off_reg;
    logic [TIMER_WIDTH-1:0]  since_on_next;
    logic [TIMER_WIDTH-1:0]  since_off_next;
    logic [TIMER_WIDTH-1:0]  inc_on;
    logic [TIMER_WIDTH-1:0]  inc_off;
    logic                    both_valid;
    logic                    rise;
    logic                    fall;
    logic signed [THR_W-1:0] temp_ext;

    // Saturating increment, restart on a valid edge
    assign inc_on     = (since_on_reg == '1) ? since_on_reg : since_on_reg + 1'b1;
    assign inc_off    = (since_off_reg == '1) ? since_off_reg : since_off_reg + 1'b1;
    assign both_valid = last_valid_reg & heater_valid;
    assign rise       = both_valid & ~last_on_reg & heater_on;
    assign fall       = both_valid & last_on_reg & ~heater_on;
    assign since_on_next  = rise ? '0 : inc_on;
    assign since_off_next = fall ? '0 : inc_off;

    // Lane findings from the updated timers
    assign temp_ext = THR_W'(temp);

    always_comb
    begin
        lane.force_off = ~temp_valid | ~heater_valid | (temp_ext > max_temp) |
                         (heater_on & (CMP_W'(since_on_next) >= CMP_W'(max_heat_seconds)));
        lane.candidate = temp_valid & (temp_ext < min_temp) &
                         (CMP_W'(since_off_next) >= CMP_W'(min_pause_seconds));
        lane.blocked   = ~heater_valid | heater_on;
    end

    // Lane state, advanced once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_on_reg    <= 1'b0;
            last_valid_reg <= 1'b0;
            since_on_reg   <= '1;
            since_off_reg  <= '1;
        end
        else if (accept)
        begin
            last_on_reg    <= heater_on;
            last_valid_reg <= heater_valid;
            since_on_reg   <= since_on_next;
            since_off_reg  <= since_off_next;
        end
    end

    // A valid rising edge restarts the on timer
    a_rise_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rise |=> since_on_reg == '0)
        else $error("on timer not restarted on rising edge");

    // Timers move only on a transfer
    a_off_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(since_off_reg) && $stable(since_on_reg))
        else $error("timer changed without a transfer");

endmodule

### src/mhis_merge.sv
// Merge stage: combines lane findings and holds the registered result.
`timescale 1ns / 1ps

module mhis_merge (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  mhis_pkg::mhis_lane_t [mhis_pkg::NUM_HEATERS-1:0] lanes,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [mhis_pkg::NUM_HEATERS-1:0]              force_off_mask,
    output logic [1:0]                                    turn_on_select
);
    import mhis_pkg::*;

    logic                   accept;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [NUM_HEATERS-1:0] force_reg;
    logic [NUM_HEATERS-1:0] force_next;
    mhis_sel_t              select_reg;
    mhis_sel_t              select_next;
    logic                   any_blocked;

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    // Force mask and last eligible heater in fixed order
    always_comb
    begin
        any_blocked = 1'b0;
        for (int i = 0; i < NUM_HEATERS; i++)
        begin
            force_next[i] = lanes[i].force_off;
            any_blocked   = any_blocked | lanes[i].blocked;
        end
        if (any_blocked)
            select_next = SEL_NONE;
        else if (lanes[2].candidate)
            select_next = SEL_DOWN;
        else if (lanes[1].candidate)
            select_next = SEL_BACK;
        else if (lanes[0].candidate)
            select_next = SEL_FRONT;
        else
            select_next = SEL_NONE;
    end

    assign out_valid_next = accept | (out_valid_reg & ~out_ready);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            force_reg  <= force_next;
            select_reg <= select_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign force_off_mask = force_reg;
    assign turn_on_select = select_reg;

    // Every transfer in yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("result missing after transfer");

    // A blocking heater suppresses any turn-on
    a_blocked_none: assert property (@(posedge clk) disable iff (!rst_n)
        accept && any_blocked |=> select_reg == SEL_NONE)
        else $error("turn-on selected while a heater is on or unknown");

endmodule

### src/multi_heater_interlock_scheduler_core.sv
// Top level of the multi-heater interlock scheduler: config registers, lanes, merge.
// Each result is registered and becomes valid in the cycle after its input transfer.
// Throughput: one tick per cycle while out_ready is high; set by the single output register stage.
// Reset (rst_n low, asynchronous): registers return to 640/480/600/60,
// timers saturate, previous levels and valid bits clear, output empties.
`timescale 1ns / 1ps

module multi_heater_interlock_scheduler_core #(
    parameter int TIMER_WIDTH = 16,
    parameter int TEMP_WIDTH  = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [TEMP_WIDTH-1:0]           temp_front,
    input  logic signed [TEMP_WIDTH-1:0]           temp_back,
    input  logic signed [TEMP_WIDTH-1:0]           temp_down,
    input  logic [mhis_pkg::NUM_HEATERS-1:0]       temp_valid_mask,
    input  logic [mhis_pkg::NUM_HEATERS-1:0]       heater_on_mask,
    input  logic [mhis_pkg::NUM_HEATERS-1:0]       heater_valid_mask,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mhis_pkg::NUM_HEATERS-1:0]       force_off_mask,
    output logic [1:0]                             turn_on_select,
    input  logic                                   cfg_we,
    input  logic [mhis_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mhis_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import mhis_pkg::*;

    localparam int THR_W = (TEMP_WIDTH > THR_MIN_W) ? TEMP_WIDTH : THR_MIN_W;

    logic signed [THR_W-1:0]      max_temp_reg;
    logic signed [THR_W-1:0]      min_temp_reg;
    logic [SEC_W-1:0]             max_heat_seconds_reg;
    logic [SEC_W-1:0]             min_pause_seconds_reg;
    logic signed [THR_W-1:0]      cfg_temp;
    logic                         accept;
    logic signed [TEMP_WIDTH-1:0] lane_temp [NUM_HEATERS];
    mhis_lane_t [NUM_HEATERS-1:0] lanes;

    // Temperature thresholds take the low sensor-width bits, sign-extended
    assign cfg_temp = THR_W'($signed(cfg_wdata[TEMP_WIDTH-1:0]));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temp_reg          <= THR_W'(MAX_TEMP_RST);
            min_temp_reg          <= THR_W'(MIN_TEMP_RST);
            max_heat_seconds_reg  <= SEC_W'(MAX_HEAT_SECONDS_RST);
            min_pause_seconds_reg <= SEC_W'(MIN_PAUSE_SECONDS_RST);
        end
        else if (cfg_we)
        begin
            unique case (mhis_reg_idx_t'(cfg_index))
                REG_MAX_TEMP:          max_temp_reg          <= cfg_temp;
                REG_MIN_TEMP:          min_temp_reg          <= cfg_temp;
                REG_MAX_HEAT_SECONDS:  max_heat_seconds_reg  <= cfg_wdata[SEC_W-1:0];
                REG_MIN_PAUSE_SECONDS: min_pause_seconds_reg <= cfg_wdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = in_valid & in_ready;

    assign lane_temp[0] = temp_front;
    assign lane_temp[1] = temp_back;
    assign lane_temp[2] = temp_down;

    // One lane per heater
    for (genvar g = 0; g < NUM_HEATERS; g++)
    begin : g_lane
        mhis_lane #(
            .TIMER_WIDTH (TIMER_WIDTH),
            .TEMP_WIDTH  (TEMP_WIDTH)
        ) u_lane (
            .clk               (clk),
            .rst_n             (rst_n),
            .accept            (accept),
            .temp              (lane_temp[g]),
            .temp_valid        (temp_valid_mask[g]),
            .heater_on         (heater_on_mask[g]),
            .heater_valid      (heater_valid_mask[g]),
            .max_temp          (max_temp_reg),
            .min_temp          (min_temp_reg),
            .max_heat_seconds  (max_heat_seconds_reg),
            .min_pause_seconds (min_pause_seconds_reg),
            .lane              (lanes[g])
        );
    end

    // Combine lanes and register the result
    mhis_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .lanes          (lanes),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .force_off_mask (force_off_mask),
        .turn_on_select (turn_on_select)
    );

endmodule

### test/multi_heater_interlock_scheduler_core_tb.sv
// Self-checking testbench for the multi-heater interlock scheduler core.
`timescale 1ns / 1ps

module multi_heater_interlock_scheduler_core_tb;

    import mhis_pkg::*;

    localparam int TEMP_W    = 12;
    localparam int TIMER_W   = 16;
    localparam int IDLE_PCT  = 13;
    localparam int STALL_MAX = 2000;

    // One sensor tick as presented to the block
    typedef struct {
        logic signed [TEMP_W-1:0] t_front;
        logic signed [TEMP_W-1:0] t_back;
        logic signed [TEMP_W-1:0] t_down;
        logic [NUM_HEATERS-1:0]   temp_ok;
        logic [NUM_HEATERS-1:0]   on;
        logic [NUM_HEATERS-1:0]   read_ok;
    } tick_t;

    // Interlock decision for one tick
    typedef struct {
        logic [NUM_HEATERS-1:0] force_off;
        mhis_sel_t              pick;
    } heat_action_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid          = 1'b0;
    logic                     in_ready;
    logic signed [TEMP_W-1:0] temp_front        = '0;
    logic signed [TEMP_W-1:0] temp_back         = '0;
    logic signed [TEMP_W-1:0] temp_down         = '0;
    logic [NUM_HEATERS-1:0]   temp_valid_mask   = '0;
    logic [NUM_HEATERS-1:0]   heater_on_mask    = '0;
    logic [NUM_HEATERS-1:0]   heater_valid_mask = '0;
    logic                     out_valid;
    logic                     out_ready         = 1'b0;
    logic [NUM_HEATERS-1:0]   force_off_mask;
    logic [1:0]               turn_on_select;
    logic                     cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index         = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata         = '0;

    multi_heater_interlock_scheduler_core #(
        .TIMER_WIDTH (TIMER_W),
        .TEMP_WIDTH  (TEMP_W)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .temp_front        (temp_front),
        .temp_back         (temp_back),
        .temp_down         (temp_down),
        .temp_valid_mask   (temp_valid_mask),
        .heater_on_mask    (heater_on_mask),
        .heater_valid_mask (heater_valid_mask),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .force_off_mask    (force_off_mask),
        .turn_on_select    (turn_on_select),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Shadow registers, reset values
    logic signed [TEMP_W-1:0] lim_hot   = TEMP_W'(MAX_TEMP_RST);
    logic signed [TEMP_W-1:0] lim_cold  = TEMP_W'(MIN_TEMP_RST);
    logic [TIMER_W-1:0]       lim_heat  = TIMER_W'(MAX_HEAT_SECONDS_RST);
    logic [TIMER_W-1:0]       lim_pause = TIMER_W'(MIN_PAUSE_SECONDS_RST);

    // Shadow heater state, reset values
    logic [NUM_HEATERS-1:0] prev_on = '0;
    logic [NUM_HEATERS-1:0] prev_ok = '0;
    logic [TIMER_W-1:0]     on_age  [NUM_HEATERS] = '{default: '1};
    logic [TIMER_W-1:0]     off_age [NUM_HEATERS] = '{default: '1};

    tick_t        pending_ticks    [$];
    heat_action_t expected_actions [$];
    tick_t        cur_tick;

    int ticks_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int hold_left    = 0;
    int stall_cycles = 0;
    int settings     = 1;
    int forced_seen  = 0;
    int pick_seen [4] = '{default: 0};

    // Advance the heater timers and work out force-off and turn-on for one tick
    function automatic heat_action_t heater_tick(input tick_t t);
        heat_action_t             a;
        logic signed [TEMP_W-1:0] temp [NUM_HEATERS];
        logic                     both_ok;
        logic                     blocked;
        a.force_off = '0;
        a.pick      = SEL_NONE;
        blocked     = 1'b0;
        temp[0]     = t.t_front;
        temp[1]     = t.t_back;
        temp[2]     = t.t_down;
        // saturating timers, restarted on validly seen edges
        for (int i = 0; i < NUM_HEATERS; i++)
        begin
            both_ok = prev_ok[i] && t.read_ok[i];
            if (on_age[i] != '1)
                on_age[i]++;
            if (off_age[i] != '1)
                off_age[i]++;
            if (both_ok && !prev_on[i] && t.on[i])
                on_age[i] = '0;
            else if (both_ok && prev_on[i] && !t.on[i])
                off_age[i] = '0;
        end
        // unsafe heaters
        for (int i = 0; i < NUM_HEATERS; i++)
        begin
            if (!t.temp_ok[i] || !t.read_ok[i] || temp[i] > lim_hot ||
                (t.on[i] && on_age[i] >= lim_heat))
                a.force_off[i] = 1'b1;
        end
        // last cold, rested heater wins, unless any is on or unreadable
        for (int i = 0; i < NUM_HEATERS; i++)
        begin
            if (!blocked)
            begin
                if (!t.read_ok[i] || t.on[i])
                    blocked = 1'b1;
                else if (t.temp_ok[i] && temp[i] < lim_cold && off_age[i] >= lim_pause)
                    a.pick = mhis_sel_t'(i + 1);
            end
        end
        if (blocked)
            a.pick = SEL_NONE;
        prev_on = t.on;
        prev_ok = t.read_ok;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 30)
            $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Sender: presents queued ticks, predicts each one on transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_actions.push_back(heater_tick(cur_tick));
                ticks_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ticks.size() != 0 &&
                    ((ticks_sent >= 100 && ticks_sent < 180) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_tick          = pending_ticks.pop_front();
                    temp_front        <= cur_tick.t_front;
                    temp_back         <= cur_tick.t_back;
                    temp_down         <= cur_tick.t_down;
                    temp_valid_mask   <= cur_tick.temp_ok;
                    heater_on_mask    <= cur_tick.on;
                    heater_valid_mask <= cur_tick.read_ok;
                    in_valid          <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer, stalls at random, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_actions.size() == 0)
                    report_mismatch("unexpected result", force_off_mask, -1);
                else
                begin
                    heat_action_t want;
                    want = expected_actions.pop_front();
                    if (force_off_mask !== want.force_off)
                        report_mismatch("force_off_mask", force_off_mask, want.force_off);
                    if (turn_on_select !== want.pick)
                        report_mismatch("turn_on_select", turn_on_select, want.pick);
                end
                results_seen++;
                forced_seen += (force_off_mask != '0);
                pick_seen[turn_on_select]++;
                if (results_seen == 330)
                    hold_left = 40;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (results_seen >= 100 && results_seen < 180) ||
                             $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic tick_t mk_tick(input int f, input int b, input int d,
                                      input logic [2:0] tok, input logic [2:0] on,
                                      input logic [2:0] rok);
        tick_t t;
        t.t_front = TEMP_W'(f);
        t.t_back  = TEMP_W'(b);
        t.t_down  = TEMP_W'(d);
        t.temp_ok = tok;
        t.on      = on;
        t.read_ok = rok;
        return t;
    endfunction

    // Temperatures clustered around the current limits, plus full range and extremes
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int v;
        int r;
        r = $urandom_range(99);
        if (r < 40)
            v = int'(lim_cold) + int'($urandom_range(16)) - 8;
        else if (r < 70)
            v = int'(lim_hot) + int'($urandom_range(16)) - 8;
        else if (r < 90)
            v = int'($urandom_range(4095)) - 2048;
        else
            v = r[0] ? 2047 : -2048;
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return TEMP_W'(v);
    endfunction

    function automatic logic [2:0] mostly_full();
        return ($urandom_range(99) < 92) ? 3'b111 : 3'($urandom);
    endfunction

    // Plausible heater behavior: levels held for runs of ticks, some noise ticks
    task automatic queue_plant(input int n);
        logic [2:0] lvl;
        int         run;
        int         r;
        tick_t      t;
        lvl = '0;
        run = 0;
        repeat (n)
        begin
            if (run == 0)
            begin
                r   = $urandom_range(99);
                lvl = (r < 55) ? 3'b000 : 3'(3'b001 << $urandom_range(2));
                if (r >= 95)
                    lvl = 3'($urandom);
                run = $urandom_range(8, 1);
            end
            run--;
            if ($urandom_range(99) < 15)
                t = mk_tick(int'($urandom), int'($urandom), int'($urandom),
                            3'($urandom), 3'($urandom), 3'($urandom));
            else
            begin
                t.t_front = pick_temp();
                t.t_back  = pick_temp();
                t.t_down  = pick_temp();
                t.temp_ok = mostly_full();
                t.on      = lvl;
                t.read_ok = mostly_full();
            end
            pending_ticks.push_back(t);
        end
    endtask

    task automatic write_reg(input mhis_reg_idx_t idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(val);
        // temperature limits carry junk above bit 11, which must be dropped
        if (idx == REG_MAX_TEMP || idx == REG_MIN_TEMP)
            data[CFG_DATA_W-1:TEMP_W] = 4'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_MAX_TEMP:          lim_hot   = data[TEMP_W-1:0];
            REG_MIN_TEMP:          lim_cold  = data[TEMP_W-1:0];
            REG_MAX_HEAT_SECONDS:  lim_heat  = data;
            REG_MIN_PAUSE_SECONDS: lim_pause = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_actions.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_limits(input int hot, input int cold, input int heat, input int pause);
        wait_drained();
        repeat (2) @(posedge clk);
        write_reg(REG_MAX_TEMP, hot);
        write_reg(REG_MIN_TEMP, cold);
        write_reg(REG_MAX_HEAT_SECONDS, heat);
        write_reg(REG_MIN_PAUSE_SECONDS, pause);
        settings++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks at reset limits (hot 640, cold 480, heat 600, pause 60)
        pending_ticks.push_back(mk_tick(0, 0, 0, 3'b000, 3'b000, 3'b000));
        pending_ticks.push_back(mk_tick(2047, -2048, 0, 3'b111, 3'b000, 3'b111));
        pending_ticks.push_back(mk_tick(-2048, 2047, 2047, 3'b111, 3'b000, 3'b111));
        pending_ticks.push_back(mk_tick(600, -1, 700, 3'b111, 3'b000, 3'b111));
        // cold heaters with unreadable temperature are never picked
        pending_ticks.push_back(mk_tick(-2048, -2048, -2048, 3'b101, 3'b000, 3'b111));
        // front turns on and stays on: blocks selection
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b001, 3'b111));
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b001, 3'b111));
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b001, 3'b111));
        // front turns off: must rest before it can be picked again
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b000, 3'b111));
        // front read-back lost, with and without an on level
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b000, 3'b110));
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b001, 3'b110));
        pending_ticks.push_back(mk_tick(100, 100, 100, 3'b111, 3'b010, 3'b111));
        // limits exactly on the boundary
        pending_ticks.push_back(mk_tick(640, 641, 480, 3'b111, 3'b100, 3'b111));
        pending_ticks.push_back(mk_tick(479, 480, 100, 3'b111, 3'b000, 3'b111));
        pending_ticks.push_back(mk_tick(-2048, -2048, -2048, 3'b111, 3'b111, 3'b111));
        pending_ticks.push_back(mk_tick(-2048, -2048, -2048, 3'b111, 3'b000, 3'b111));
        pending_ticks.push_back(mk_tick(-2048, -2048, -2048, 3'b000, 3'b111, 3'b000));
        pending_ticks.push_back(mk_tick(2047, 2047, 2047, 3'b111, 3'b000, 3'b111));
        queue_plant(60);

        // short timers, narrow band
        set_limits(300, 100, 4, 2);
        queue_plant(100);

        // widest band, longest timers
        set_limits(2047, -2048, 65535, 65535);
        queue_plant(50);

        // inverted band: a heater can be forced off and picked at once; zero timers
        set_limits(-2048, 2047, 0, 0);
        pending_ticks.push_back(mk_tick(0, 0, 0, 3'b111, 3'b000, 3'b111));
        pending_ticks.push_back(mk_tick(0, 0, 0, 3'b111, 3'b010, 3'b111));
        queue_plant(50);

        // random limits; the receiver hold-off lands in this phase
        set_limits(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                   $urandom_range(8), $urandom_range(6));
        queue_plant(140);

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Ran %0d ticks over %0d limit settings, %0d with a force-off.",
                 ticks_sent, settings, forced_seen);
        $display("Turn-on picks none/front/back/down: %0d/%0d/%0d/%0d, mismatches: %0d.",
                 pick_seen[0], pick_seen[1], pick_seen[2], pick_seen[3], mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
